@@ rtl/ihcu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ihcu_pkg
// Shared types, codes and constants of the IPv4 receive header checker.
// ----------------------------------------------------------------------------
package ihcu_pkg;

	// Verdict codes
	localparam logic [3:0] VERDICT_DELIVERED = 4'd0;
	localparam logic [3:0] VERDICT_DISABLED  = 4'd1;
	localparam logic [3:0] VERDICT_SHORT     = 4'd2;
	localparam logic [3:0] VERDICT_NOT_IPV4  = 4'd3;
	localparam logic [3:0] VERDICT_BAD_VIHL  = 4'd4;
	localparam logic [3:0] VERDICT_CHECKSUM  = 4'd5;
	localparam logic [3:0] VERDICT_LENGTH    = 4'd6;
	localparam logic [3:0] VERDICT_FRAGMENT  = 4'd7;
	localparam logic [3:0] VERDICT_UNKNOWN   = 4'd8;

	// Configuration register indexes (byte address 4*index)
	localparam int          ADDR_W         = 4;
	localparam logic [1:0]  REG_ENABLE     = 2'd0;
	localparam logic [1:0]  REG_HANDLERS   = 2'd1;
	localparam logic [1:0]  REG_PROTO_TBL  = 2'd2;

	// Frame layout and check constants
	localparam logic [15:0] ETH_LEN_C      = 16'd14;
	localparam logic [15:0] MIN_FRAME_C    = 16'd34;
	localparam logic [15:0] IPV4_TYPE_C    = 16'h0800;
	localparam logic [15:0] SUM_GOOD_C     = 16'hFFFF;
	localparam logic [15:0] INDEX_MAX_C    = 16'hFFFF;
	localparam logic [12:0] FRAG_OFS_MASK  = 13'h1FFF;
	localparam int          MF_BIT_C       = 13;
	localparam logic [3:0]  IPV4_VERSION_C = 4'd4;
	localparam logic [3:0]  MIN_IHL_C      = 4'd5;

	// Protocol table
	localparam int          TABLE_SLOTS    = 4;
	localparam logic [3:0]  MAX_HANDLERS_C = 4'd4;

	// Queue between the parser and the verdict stage
	localparam int          QUEUE_DEPTH_C  = 2;

	// Header fields of one finished frame
	typedef struct packed {
		logic [15:0] seen_bytes;
		logic [15:0] ether_type;
		logic [7:0]  ver_ihl;
		logic [15:0] hdr_sum;
		logic [15:0] ip_length;
		logic [15:0] frag_word;
		logic [7:0]  protocol;
		logic [31:0] source;
	} frame_sum_t;

	// Live configuration seen by the verdict stage
	typedef struct packed {
		logic        enable;
		logic [2:0]  handler_count;
		logic [31:0] protocol_table;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/ihcu_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ihcu_fifo
// Small register queue: one push per cycle unless full, one pop unless empty, first word out.
// ----------------------------------------------------------------------------
module ihcu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  full,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/ihcu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ihcu_front
// Byte parser: counts frame bytes, captures header fields and keeps the
// ones-complement header sum; pushes one summary word on the last byte.
// ----------------------------------------------------------------------------
module ihcu_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         frame_byte,
	input  wire logic               last_byte,
	output logic                    push,
	output ihcu_pkg::frame_sum_t    summary
);
	localparam logic [15:0] POS_TYPE_HI = 16'd12;
	localparam logic [15:0] POS_TYPE_LO = 16'd13;
	localparam logic [15:0] POS_VIHL    = 16'd14;
	localparam logic [15:0] POS_LEN_HI  = 16'd16;
	localparam logic [15:0] POS_LEN_LO  = 16'd17;
	localparam logic [15:0] POS_FF_HI   = 16'd20;
	localparam logic [15:0] POS_FF_LO   = 16'd21;
	localparam logic [15:0] POS_PROTO   = 16'd23;
	localparam logic [15:0] POS_SRC0    = 16'd26;
	localparam logic [15:0] POS_SRC1    = 16'd27;
	localparam logic [15:0] POS_SRC2    = 16'd28;
	localparam logic [15:0] POS_SRC3    = 16'd29;

	logic [15:0] byte_index_q, byte_index_n;
	logic [15:0] ether_type_q, ether_type_n;
	logic [7:0]  ver_ihl_q,    ver_ihl_n;
	logic [15:0] sum_q,        sum_n;
	logic [7:0]  pend_q,       pend_n;
	logic [31:0] len_frag_q,   len_frag_n;
	logic [39:0] proto_src_q,  proto_src_n;
	logic [5:0]  hdr_len;
	logic [16:0] sum_wide;
	logic        in_header;

	// Capture header fields at their byte positions
	always_comb begin
		ether_type_n = ether_type_q;
		ver_ihl_n    = ver_ihl_q;
		len_frag_n   = len_frag_q;
		proto_src_n  = proto_src_q;
		case (byte_index_q)
			POS_TYPE_HI: ether_type_n[15:8]  = frame_byte;
			POS_TYPE_LO: ether_type_n[7:0]   = frame_byte;
			POS_VIHL:    ver_ihl_n           = frame_byte;
			POS_LEN_HI:  len_frag_n[31:24]   = frame_byte;
			POS_LEN_LO:  len_frag_n[23:16]   = frame_byte;
			POS_FF_HI:   len_frag_n[15:8]    = frame_byte;
			POS_FF_LO:   len_frag_n[7:0]     = frame_byte;
			POS_PROTO:   proto_src_n[39:32]  = frame_byte;
			POS_SRC0:    proto_src_n[31:24]  = frame_byte;
			POS_SRC1:    proto_src_n[23:16]  = frame_byte;
			POS_SRC2:    proto_src_n[15:8]   = frame_byte;
			POS_SRC3:    proto_src_n[7:0]    = frame_byte;
			default: ;
		endcase
	end

	// Accumulate header words with end-around carry
	always_comb begin
		hdr_len   = {ver_ihl_n[3:0], 2'b00};
		in_header = (byte_index_q >= ihcu_pkg::ETH_LEN_C) &&
		            (byte_index_q < (ihcu_pkg::ETH_LEN_C + {10'b0, hdr_len}));
		sum_wide  = {1'b0, sum_q} + {1'b0, pend_q, frame_byte};
		pend_n    = pend_q;
		sum_n     = sum_q;
		if (in_header) begin
			if (!byte_index_q[0]) begin
				pend_n = frame_byte;
			end else begin
				sum_n = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
			end
		end
		byte_index_n = (byte_index_q != ihcu_pkg::INDEX_MAX_C) ?
		               (byte_index_q + 16'd1) : byte_index_q;
	end

	// Hand the finished frame to the queue
	assign push = accept && last_byte;
	always_comb begin
		summary.seen_bytes = byte_index_n;
		summary.ether_type = ether_type_n;
		summary.ver_ihl    = ver_ihl_n;
		summary.hdr_sum    = sum_n;
		summary.ip_length  = len_frag_n[31:16];
		summary.frag_word  = len_frag_n[15:0];
		summary.protocol   = proto_src_n[39:32];
		summary.source     = proto_src_n[31:0];
	end

	// Hold per-frame state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			ether_type_q <= '0;
			ver_ihl_q    <= '0;
			sum_q        <= '0;
			pend_q       <= '0;
			len_frag_q   <= '0;
			proto_src_q  <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_index_q <= '0;
				ether_type_q <= '0;
				ver_ihl_q    <= '0;
				sum_q        <= '0;
				pend_q       <= '0;
				len_frag_q   <= '0;
				proto_src_q  <= '0;
			end else begin
				byte_index_q <= byte_index_n;
				ether_type_q <= ether_type_n;
				ver_ihl_q    <= ver_ihl_n;
				sum_q        <= sum_n;
				pend_q       <= pend_n;
				len_frag_q   <= len_frag_n;
				proto_src_q  <= proto_src_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/ihcu_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ihcu_back
// Verdict stage: checks one frame summary, searches the protocol table,
// counts accepted packets and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module ihcu_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ihcu_pkg::cfg_t       cfg,
	input  wire logic                 queue_empty,
	input  wire ihcu_pkg::frame_sum_t summary,
	output logic                      pop,
	input  wire logic                 result_stall,
	output logic                      result_valid,
	output logic [3:0]                verdict,
	output logic [1:0]                handler_slot,
	output logic [7:0]                protocol_number,
	output logic [31:0]               source_address,
	output logic [6:0]                payload_offset,
	output logic [15:0]               payload_length,
	output logic [31:0]               accepted_count
);
	logic        valid_q;
	logic [3:0]  verdict_q;
	logic [1:0]  slot_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [6:0]  poff_q;
	logic [15:0] plen_q;
	logic [31:0] count_q;

	logic [5:0]  hdr_len;
	logic [6:0]  data_ofs;
	logic [3:0]  limit;
	logic        pass;
	logic        found;
	logic [1:0]  slot;
	logic [3:0]  verdict_n;

	// Take a summary whenever the output word is free or leaving
	assign pop = !queue_empty && (!valid_q || !result_stall);

	// Run the checks in priority order
	always_comb begin
		hdr_len   = {summary.ver_ihl[3:0], 2'b00};
		data_ofs  = 7'(ihcu_pkg::ETH_LEN_C) + {1'b0, hdr_len};
		pass      = 1'b0;
		if (!cfg.enable) begin
			verdict_n = ihcu_pkg::VERDICT_DISABLED;
		end else if (summary.seen_bytes < ihcu_pkg::MIN_FRAME_C) begin
			verdict_n = ihcu_pkg::VERDICT_SHORT;
		end else if (summary.ether_type != ihcu_pkg::IPV4_TYPE_C) begin
			verdict_n = ihcu_pkg::VERDICT_NOT_IPV4;
		end else if (summary.ver_ihl[7:4] != ihcu_pkg::IPV4_VERSION_C ||
		             summary.ver_ihl[3:0] < ihcu_pkg::MIN_IHL_C) begin
			verdict_n = ihcu_pkg::VERDICT_BAD_VIHL;
		end else if (summary.seen_bytes < {9'b0, data_ofs}) begin
			verdict_n = ihcu_pkg::VERDICT_SHORT;
		end else if (summary.hdr_sum != ihcu_pkg::SUM_GOOD_C) begin
			verdict_n = ihcu_pkg::VERDICT_CHECKSUM;
		end else if (summary.ip_length < {10'b0, hdr_len} ||
		             ({1'b0, summary.ip_length} + {1'b0, ihcu_pkg::ETH_LEN_C}) >
		             {1'b0, summary.seen_bytes}) begin
			verdict_n = ihcu_pkg::VERDICT_LENGTH;
		end else if (summary.frag_word[ihcu_pkg::MF_BIT_C] ||
		             (summary.frag_word[12:0] & ihcu_pkg::FRAG_OFS_MASK) != 13'd0) begin
			verdict_n = ihcu_pkg::VERDICT_FRAGMENT;
		end else begin
			pass      = 1'b1;
			verdict_n = found ? ihcu_pkg::VERDICT_DELIVERED : ihcu_pkg::VERDICT_UNKNOWN;
		end
	end

	// Search the table slots in use; the lowest match wins
	always_comb begin
		limit = {1'b0, cfg.handler_count};
		if (limit > ihcu_pkg::MAX_HANDLERS_C) begin
			limit = ihcu_pkg::MAX_HANDLERS_C;
		end
		if (limit > 4'(ihcu_pkg::TABLE_SLOTS)) begin
			limit = 4'(ihcu_pkg::TABLE_SLOTS);
		end
		found = 1'b0;
		slot  = 2'd0;
		for (int i = ihcu_pkg::TABLE_SLOTS - 1; i >= 0; i--) begin
			if (4'(i) < limit && cfg.protocol_table[i*8 +: 8] == summary.protocol) begin
				found = 1'b1;
				slot  = 2'(i);
			end
		end
	end

	// Load the result word and bump the accepted count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (pass) begin
					count_q <= count_q + 32'd1;
				end
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict_n;
			slot_q    <= (pass && found) ? slot : 2'd0;
			proto_q   <= summary.protocol;
			src_q     <= summary.source;
			poff_q    <= pass ? data_ofs : 7'd0;
			plen_q    <= pass ? (summary.ip_length - {10'b0, hdr_len}) : 16'd0;
		end
	end

	assign result_valid    = valid_q;
	assign verdict         = verdict_q;
	assign handler_slot    = slot_q;
	assign protocol_number = proto_q;
	assign source_address  = src_q;
	assign payload_offset  = poff_q;
	assign payload_length  = plen_q;
	assign accepted_count  = count_q;

endmodule
`default_nettype wire

@@ rtl/ipv4_receive_header_checker_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_receive_header_checker_unit
// IPv4 receive header checker with protocol demux verdict.
// ----------------------------------------------------------------------------
// Frame bytes enter on frame_valid/frame_stall with frame_byte and last_byte;
// a byte is taken at an edge with frame_valid high and frame_stall low. The
// parser can take a byte every cycle and waits only while the queue is full.
// On the last byte the parser pushes the captured header fields into a short
// queue (QUEUE_DEPTH words). The verdict stage pops one word per cycle when
// its result register is free or leaving, raising result_valid; the word
// is held until result_stall is low. While the receiver stalls, the queue
// fills; once full, frame_stall rises and the parser holds its position,
// even in the middle of a frame.
// Throughput, stalls aside: one byte, one result per cycle (one-byte frames).
// Registers sit on an APB-style port: enable at 0x0, handler_count at 0x4,
// protocol_table at 0x8; pready is always high.
// Reset clears the registers, the accepted count, the parser and the queue.
// ----------------------------------------------------------------------------
module ipv4_receive_header_checker_unit #(
	parameter int QUEUE_DEPTH = ihcu_pkg::QUEUE_DEPTH_C
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ihcu_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	input  wire logic                        frame_valid,
	output logic                             frame_stall,
	input  wire logic [7:0]                  frame_byte,
	input  wire logic                        last_byte,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [3:0]                       verdict,
	output logic [1:0]                       handler_slot,
	output logic [7:0]                       protocol_number,
	output logic [31:0]                      source_address,
	output logic [6:0]                       payload_offset,
	output logic [15:0]                      payload_length,
	output logic [31:0]                      accepted_count
);
	localparam int SUM_W = $bits(ihcu_pkg::frame_sum_t);

	ihcu_pkg::cfg_t       cfg_q;
	ihcu_pkg::frame_sum_t push_sum, pop_sum;
	logic [SUM_W-1:0]     pop_bits;
	logic                 accept, push, pop, full, empty, cfg_write;
	logic [1:0]           reg_index;

	// Configuration registers
	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (reg_index)
				ihcu_pkg::REG_ENABLE:    cfg_q.enable         <= pwdata[0];
				ihcu_pkg::REG_HANDLERS:  cfg_q.handler_count  <= pwdata[2:0];
				ihcu_pkg::REG_PROTO_TBL: cfg_q.protocol_table <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			ihcu_pkg::REG_ENABLE:    prdata = {31'b0, cfg_q.enable};
			ihcu_pkg::REG_HANDLERS:  prdata = {29'b0, cfg_q.handler_count};
			ihcu_pkg::REG_PROTO_TBL: prdata = cfg_q.protocol_table;
			default:                 prdata = 32'd0;
		endcase
	end

	// Front: parse bytes
	assign frame_stall = full;
	assign accept      = frame_valid && !full;

	ihcu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (frame_byte),
		.last_byte  (last_byte),
		.push       (push),
		.summary    (push_sum)
	);

	// Queue between parser and verdict stage
	ihcu_fifo #(
		.WIDTH (SUM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_sum),
		.pop       (pop),
		.pop_data  (pop_bits),
		.full      (full),
		.empty     (empty)
	);

	assign pop_sum = ihcu_pkg::frame_sum_t'(pop_bits);

	// Back: verdict and result word
	ihcu_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.queue_empty     (empty),
		.summary         (pop_sum),
		.pop             (pop),
		.result_stall    (result_stall),
		.result_valid    (result_valid),
		.verdict         (verdict),
		.handler_slot    (handler_slot),
		.protocol_number (protocol_number),
		.source_address  (source_address),
		.payload_offset  (payload_offset),
		.payload_length  (payload_length),
		.accepted_count  (accepted_count)
	);

endmodule
`default_nettype wire

@@ rtl/ihcu_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ihcu_checker
// Port-level checks on the result channel of the header checker.
// ----------------------------------------------------------------------------
module ihcu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [3:0]  verdict,
	input wire logic [1:0]  handler_slot,
	input wire logic [6:0]  payload_offset,
	input wire logic [15:0] payload_length
);

	// Hold a stalled result word
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_hold_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(verdict))
		else $error("verdict changed while stalled");

	// Verdict code stays in range
	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> verdict <= ihcu_pkg::VERDICT_UNKNOWN)
		else $error("verdict code out of range");

	// Slot only reported on delivery
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict != ihcu_pkg::VERDICT_DELIVERED |-> handler_slot == 2'd0)
		else $error("handler slot set on a dropped frame");

	// Payload window only for packets that passed all checks
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict != ihcu_pkg::VERDICT_DELIVERED &&
		verdict != ihcu_pkg::VERDICT_UNKNOWN
		|-> payload_offset == 7'd0 && payload_length == 16'd0)
		else $error("payload window set on a dropped frame");

endmodule

bind ipv4_receive_header_checker_unit ihcu_checker u_ihcu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.verdict        (verdict),
	.handler_slot   (handler_slot),
	.payload_offset (payload_offset),
	.payload_length (payload_length)
);
`default_nettype wire

@@ verif/ipv4_receive_header_checker_unit_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_receive_header_checker_unit_tb
// Self-checking bench for the IPv4 receive header checker.
// Frames are built from well-formed IPv4 headers with random content, then
// damaged on purpose (runts, wrong EtherType, bad version/IHL, cut header,
// bad checksum, bad length, fragments, noise). A byte-level predictor in a
// scoreboard class works out the verdict of each frame, and every result
// word is compared field by field, in order, with the oldest prediction.
// Both sides idle at random; one long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module ipv4_receive_header_checker_unit_tb;
	import ihcu_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          DRAIN_CYCLES  = 20;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          ITEM_TARGET   = 1950;
	localparam int          RANDOM_FRAMES = 8;

	typedef enum int {
		FK_GOOD,
		FK_RUNT,
		FK_NOT_IPV4,
		FK_BAD_VERSION,
		FK_LOW_IHL,
		FK_CUT_HEADER,
		FK_BAD_SUM,
		FK_LEN_UNDER,
		FK_LEN_OVER,
		FK_FRAGMENT,
		FK_NOISE
	} frame_kind_e;

	typedef struct {
		logic [3:0]  verdict;
		logic [1:0]  slot;
		logic [7:0]  proto;
		logic [31:0] source;
		logic [6:0]  offset;
		logic [15:0] length;
		logic [31:0] count;
	} verdict_t;

	// Byte-level model of the checker and the queue of verdicts it predicts
	class header_verdict_scoreboard;
		verdict_t    pending_verdicts[$];
		logic        enable_reg;
		logic [2:0]  handler_cnt;
		logic [31:0] proto_tbl;
		logic [15:0] byte_idx;
		logic [15:0] eth_type;
		logic [7:0]  ver_ihl;
		logic [16:0] hdr_sum;
		logic [7:0]  hi_byte;
		logic [15:0] len_field;
		logic [15:0] frag_field;
		logic [7:0]  proto_fld;
		logic [31:0] src_addr;
		logic [31:0] accepted;
		int          mismatches;

		function new();
			enable_reg  = 1'b0;
			handler_cnt = '0;
			proto_tbl   = '0;
			accepted    = '0;
			mismatches  = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			byte_idx   = '0;
			eth_type   = '0;
			ver_ihl    = '0;
			hdr_sum    = '0;
			hi_byte    = '0;
			len_field  = '0;
			frag_field = '0;
			proto_fld  = '0;
			src_addr   = '0;
		endfunction

		function int outstanding();
			return pending_verdicts.size();
		endfunction

		// Note one accepted frame byte; on the last one, predict the verdict
		function void take_byte(logic [7:0] b, logic last);
			int unsigned p;
			int unsigned hlen;
			int unsigned flen;
			int unsigned total;
			int unsigned limit;
			int unsigned i;
			logic        found;
			verdict_t    v;
			p = byte_idx;
			case (p)
				12: eth_type[15:8] = b;
				13: eth_type[7:0] = b;
				14: ver_ihl = b;
				16: len_field[15:8] = b;
				17: len_field[7:0] = b;
				20: frag_field[15:8] = b;
				21: frag_field[7:0] = b;
				23: proto_fld = b;
				26: src_addr[31:24] = b;
				27: src_addr[23:16] = b;
				28: src_addr[15:8] = b;
				29: src_addr[7:0] = b;
				default: ;
			endcase

			// fold header words in as they complete
			hlen = ver_ihl[3:0] * 4;
			if (p >= ETH_LEN_C && p < ETH_LEN_C + hlen) begin
				if (((p - ETH_LEN_C) % 2) == 0) begin
					hi_byte = b;
				end else begin
					hdr_sum = hdr_sum + {hi_byte, b};
					if (hdr_sum > 17'hFFFF) hdr_sum = hdr_sum - 17'hFFFF;
				end
			end

			if (byte_idx != INDEX_MAX_C) byte_idx++;
			if (!last) return;

			flen     = byte_idx;
			total    = len_field;
			v.slot   = '0;
			v.proto  = proto_fld;
			v.source = src_addr;
			v.offset = '0;
			v.length = '0;
			if (!enable_reg) v.verdict = VERDICT_DISABLED;
			else if (flen < MIN_FRAME_C) v.verdict = VERDICT_SHORT;
			else if (eth_type != IPV4_TYPE_C) v.verdict = VERDICT_NOT_IPV4;
			else if (ver_ihl[7:4] != IPV4_VERSION_C || ver_ihl[3:0] < MIN_IHL_C)
				v.verdict = VERDICT_BAD_VIHL;
			else if (flen < ETH_LEN_C + hlen) v.verdict = VERDICT_SHORT;
			else if (hdr_sum != SUM_GOOD_C) v.verdict = VERDICT_CHECKSUM;
			else if (total < hlen || ETH_LEN_C + total > flen) v.verdict = VERDICT_LENGTH;
			else if (frag_field[MF_BIT_C] || (frag_field[12:0] & FRAG_OFS_MASK) != '0)
				v.verdict = VERDICT_FRAGMENT;
			else begin
				// passed: count it, then search the protocol table
				accepted++;
				v.offset  = 7'(ETH_LEN_C + hlen);
				v.length  = 16'(total - hlen);
				v.verdict = VERDICT_UNKNOWN;
				limit = handler_cnt;
				if (limit > MAX_HANDLERS_C) limit = MAX_HANDLERS_C;
				if (limit > TABLE_SLOTS) limit = TABLE_SLOTS;
				found = 1'b0;
				for (i = 0; i < limit; i++) begin
					if (!found && proto_tbl[8*i +: 8] == proto_fld) begin
						found     = 1'b1;
						v.verdict = VERDICT_DELIVERED;
						v.slot    = 2'(i);
					end
				end
			end
			v.count = accepted;
			pending_verdicts.push_back(v);
			clear_frame();
		endfunction

		// Compare one result word with the oldest prediction
		function void check_verdict(verdict_t got);
			verdict_t want;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing predicted: verdict=%0d src=%h",
						$time, got.verdict, got.source);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.verdict !== want.verdict || got.slot !== want.slot ||
						got.proto !== want.proto || got.source !== want.source ||
						got.offset !== want.offset || got.length !== want.length ||
						got.count !== want.count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch, expected v=%0d slot=%0d proto=%0d src=%h off=%0d len=%0d cnt=%0d",
							$time, want.verdict, want.slot, want.proto, want.source,
							want.offset, want.length, want.count);
						$display("%0t:           actual   v=%0d slot=%0d proto=%0d src=%h off=%0d len=%0d cnt=%0d",
							$time, got.verdict, got.slot, got.proto, got.source,
							got.offset, got.length, got.count);
					end
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               frame_valid;
	logic               frame_stall;
	logic [7:0]         frame_byte;
	logic               last_byte;
	logic               result_valid;
	logic               result_stall;
	logic [3:0]         verdict;
	logic [1:0]         handler_slot;
	logic [7:0]         protocol_number;
	logic [31:0]        source_address;
	logic [6:0]         payload_offset;
	logic [15:0]        payload_length;
	logic [31:0]        accepted_count;

	header_verdict_scoreboard verdict_board;
	logic [7:0]  frame_bytes[$];
	int          sent_bytes = 0;
	bit          calm = 1'b0;
	bit          hold_request = 1'b0;

	ipv4_receive_header_checker_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.frame_valid     (frame_valid),
		.frame_stall     (frame_stall),
		.frame_byte      (frame_byte),
		.last_byte       (last_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.verdict         (verdict),
		.handler_slot    (handler_slot),
		.protocol_number (protocol_number),
		.source_address  (source_address),
		.payload_offset  (payload_offset),
		.payload_length  (payload_length),
		.accepted_count  (accepted_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Setup cycle, then access cycle; the register takes the write on pready
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic en, input logic [2:0] cnt, input logic [31:0] tbl);
		reg_write(REG_ENABLE, {31'd0, en});
		reg_write(REG_HANDLERS, {29'd0, cnt});
		reg_write(REG_PROTO_TBL, tbl);
		verdict_board.enable_reg  = en;
		verdict_board.handler_cnt = cnt;
		verdict_board.proto_tbl   = tbl;
	endtask

	// Drop valid and wait until every predicted verdict has come back
	task automatic wait_idle();
		frame_valid <= 1'b0;
		while (verdict_board.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Build one frame of the given kind and offer it byte by byte.
	// For runts and noise, pay_req is the whole frame length.
	task automatic offer_frame(input frame_kind_e kind, input int ihl_req = -1,
			input int pay_req = -1, input int proto_req = -1, input int pad_req = -1);
		int          ihl;
		int          hlen;
		int          hbytes;
		int          pay;
		int          pad;
		int          total;
		int          flen;
		int          n;
		logic [7:0]  hdr[$];
		logic [15:0] etype;
		logic [15:0] ffw;
		logic [15:0] tl;
		logic [16:0] csum;
		logic [7:0]  proto;
		logic [3:0]  ver;
		frame_bytes.delete();
		if (kind == FK_RUNT || kind == FK_NOISE) begin
			if (pay_req >= 0) flen = pay_req;
			else if (kind == FK_RUNT) flen = $urandom_range(1, 33);
			else flen = $urandom_range(1, 90);
			repeat (flen) frame_bytes.push_back(8'($urandom));
		end else begin
			ihl = (ihl_req >= 0) ? ihl_req :
				(($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5);
			if (kind == FK_LOW_IHL) ihl = $urandom_range(0, 4);
			if (kind == FK_CUT_HEADER && ihl < 6) ihl = $urandom_range(6, 15);
			hlen   = ihl * 4;
			hbytes = (hlen < 20) ? 20 : hlen;
			pay = (pay_req >= 0) ? pay_req :
				(($urandom_range(7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 30));
			if (pad_req >= 0) pad = pad_req;
			else pad = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : 0;
			total = hlen + pay;
			if (kind == FK_LEN_UNDER) total = $urandom_range(0, hlen - 1);
			if (kind == FK_LEN_OVER) total = hlen + pay + pad + $urandom_range(1, 40);
			tl = 16'(total);

			// reserved and DF bits are don't-care; fragments set MF and/or offset
			ffw = {2'($urandom), 14'd0};
			if (kind == FK_FRAGMENT) begin
				case ($urandom_range(2))
					0: ffw[MF_BIT_C] = 1'b1;
					1: ffw[12:0] = 13'($urandom_range(1, FRAG_OFS_MASK));
					default: begin
						ffw[MF_BIT_C] = 1'b1;
						ffw[12:0] = 13'($urandom_range(1, FRAG_OFS_MASK));
					end
				endcase
			end

			if (proto_req >= 0) proto = 8'(proto_req);
			else if ($urandom_range(9) < 7)
				proto = verdict_board.proto_tbl[8*$urandom_range(3) +: 8];
			else proto = 8'($urandom);

			etype = IPV4_TYPE_C;
			if (kind == FK_NOT_IPV4) begin
				etype = 16'($urandom);
				if (etype == IPV4_TYPE_C) etype = 16'h86DD;
			end
			ver = IPV4_VERSION_C;
			if (kind == FK_BAD_VERSION) begin
				ver = 4'($urandom_range(0, 15));
				if (ver == IPV4_VERSION_C) ver = 4'd6;
			end

			// IP header with a zero checksum field, then fill the checksum in
			hdr.push_back({ver, 4'(ihl)});
			hdr.push_back(8'($urandom));
			hdr.push_back(tl[15:8]);
			hdr.push_back(tl[7:0]);
			hdr.push_back(8'($urandom));
			hdr.push_back(8'($urandom));
			hdr.push_back(ffw[15:8]);
			hdr.push_back(ffw[7:0]);
			hdr.push_back(8'($urandom));
			hdr.push_back(proto);
			hdr.push_back(8'd0);
			hdr.push_back(8'd0);
			repeat (hbytes - 12) hdr.push_back(8'($urandom));
			csum = '0;
			for (n = 0; n + 1 < hlen; n += 2) begin
				csum = csum + {hdr[n], hdr[n+1]};
				if (csum > 17'hFFFF) csum = csum - 17'hFFFF;
			end
			hdr[10] = ~csum[15:8];
			hdr[11] = ~csum[7:0];
			if (kind == FK_BAD_SUM) hdr[8] = hdr[8] ^ 8'($urandom_range(1, 255));

			repeat (12) frame_bytes.push_back(8'($urandom));
			frame_bytes.push_back(etype[15:8]);
			frame_bytes.push_back(etype[7:0]);
			foreach (hdr[k]) frame_bytes.push_back(hdr[k]);
			repeat (pay + pad) frame_bytes.push_back(8'($urandom));
			if (kind == FK_CUT_HEADER) begin
				flen = $urandom_range(MIN_FRAME_C, ETH_LEN_C + hlen - 1);
				while (frame_bytes.size() > flen) void'(frame_bytes.pop_back());
			end
		end

		// Offer the bytes; a random gap with valid low may come first
		for (n = 0; n < frame_bytes.size(); n++) begin
			if (!calm && $urandom_range(99) < 11) begin
				frame_valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			frame_valid <= 1'b1;
			frame_byte  <= frame_bytes[n];
			last_byte   <= (n == frame_bytes.size() - 1);
			do @(posedge clk); while (frame_stall);
			verdict_board.take_byte(frame_bytes[n], n == frame_bytes.size() - 1);
		end
		sent_bytes += frame_bytes.size();
	endtask

	// Result side: check accepted words, stall at random or for a hold-off
	initial begin : result_sink
		int       hold_left;
		verdict_t got;
		hold_left    = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && !result_stall) begin
				got.verdict = verdict;
				got.slot    = handler_slot;
				got.proto   = protocol_number;
				got.source  = source_address;
				got.offset  = payload_offset;
				got.length  = payload_length;
				got.count   = accepted_count;
				verdict_board.check_verdict(got);
			end
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !calm && ($urandom_range(99) < 11);
			end
		end
	end

	// End the run if it hangs
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[ipv4_receive_header_checker_unit] ERROR");
		$finish;
	end

	initial begin : stimulus
		int          rnd_frames;
		int          k;
		logic [31:0] tbl;
		frame_kind_e kind;
		verdict_board = new();
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		frame_valid = 1'b0;
		frame_byte  = '0;
		last_byte   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: everything is dropped as disabled
		offer_frame(FK_GOOD);
		offer_frame(FK_RUNT);
		wait_idle();

		// slot 3 repeats slot 1, so the first match must win
		set_config(1'b1, 3'd4, 32'h06_11_06_01);
		offer_frame(FK_GOOD, 5, 0, 1);
		offer_frame(FK_GOOD, 15, 0, 6);
		offer_frame(FK_GOOD, -1, -1, 17);
		offer_frame(FK_GOOD, -1, -1, 99);
		offer_frame(FK_RUNT, -1, 1);
		offer_frame(FK_RUNT, -1, 33);
		offer_frame(FK_NOT_IPV4);
		offer_frame(FK_BAD_VERSION);
		offer_frame(FK_LOW_IHL);
		offer_frame(FK_CUT_HEADER);
		offer_frame(FK_BAD_SUM);
		offer_frame(FK_LEN_UNDER);
		offer_frame(FK_LEN_OVER);
		offer_frame(FK_FRAGMENT);
		offer_frame(FK_FRAGMENT);
		wait_idle();

		// handler count at its top, all-ones table
		set_config(1'b1, 3'd7, 32'hFFFF_FFFF);
		offer_frame(FK_GOOD, -1, -1, 255);
		offer_frame(FK_GOOD, -1, -1, 0);
		wait_idle();

		// no handlers: passing packets are unknown protocol
		set_config(1'b1, 3'd0, 32'h0);
		offer_frame(FK_GOOD, -1, -1, 0);
		wait_idle();

		// count above the table size
		set_config(1'b1, 3'd5, 32'h0);
		offer_frame(FK_GOOD, 5, -1, 0, 5);

		// hold the result side off while short frames keep coming
		hold_request = 1'b1;
		repeat (16) offer_frame(FK_NOISE, -1, $urandom_range(1, 3));
		wait_idle();

		set_config(1'b0, 3'd4, $urandom);
		offer_frame(FK_GOOD);
		offer_frame(FK_NOISE);

		// random part: mostly good packets, new settings every few frames
		rnd_frames = 0;
		while (sent_bytes < ITEM_TARGET || rnd_frames < RANDOM_FRAMES) begin
			if (rnd_frames % 8 == 0) begin
				wait_idle();
				for (k = 0; k < 4; k++)
					tbl[8*k +: 8] = ($urandom_range(1) == 1) ?
						8'($urandom_range(0, 20)) : 8'($urandom);
				set_config($urandom_range(9) != 0, 3'($urandom_range(7)), tbl);
			end
			calm = (rnd_frames >= 1 && rnd_frames < 7);
			kind = ($urandom_range(99) < 55) ? FK_GOOD :
				frame_kind_e'($urandom_range(FK_RUNT, FK_NOISE));
			offer_frame(kind);
			rnd_frames++;
		end
		calm = 1'b0;

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (verdict_board.mismatches == 0 && verdict_board.outstanding() == 0)
			$display("[ipv4_receive_header_checker_unit] OK");
		else
			$display("[ipv4_receive_header_checker_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

@@ ipv4_receive_header_checker_unit.f @@
rtl/ihcu_pkg.sv
rtl/ihcu_fifo.sv
rtl/ihcu_front.sv
rtl/ihcu_back.sv
rtl/ipv4_receive_header_checker_unit.sv
rtl/ihcu_checker.sv
verif/ipv4_receive_header_checker_unit_tb.sv
